// ----- hdl/wwarp_pkg.sv -----
// Shared types, constants and the sine table entry function for the water wave
// warp address generator. No dependencies.

package wwarp_pkg;

    localparam int COORD_W    = 12;
    localparam int INDEX_W    = 24;
    localparam int AMPL_W     = 16;
    localparam int ANGLE_W    = 16;
    localparam int SINE_W     = 16;
    localparam int ENTRY_W    = 15;
    localparam int FRAME_W    = 13;
    localparam int WARP_W     = 36;
    localparam int FRAC_SHIFT = 22;
    localparam int SRC_W      = 14;
    localparam int LIN_W      = 28;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REGION_W   = 48;
    localparam int FSIZE_W    = 26;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_AMPL_X        = 3'd0,
        REG_AMPL_Y        = 3'd1,
        REG_FREQ_X        = 3'd2,
        REG_FREQ_Y        = 3'd3,
        REG_PHASE_X       = 3'd4,
        REG_PHASE_Y       = 3'd5,
        REG_REGION_BOUNDS = 3'd6,
        REG_FRAME_SIZE    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_FETCH = 2'd0,
        ACT_COPY  = 2'd1,
        ACT_SKIP  = 2'd2
    } action_t;

    // Taylor series to x^11 in Q30, rounded to Q14
    function automatic logic [ENTRY_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        acc  = acc - signed'(term);
        if (acc < 0)
        begin
            acc = 0;
        end
        return ENTRY_W'((acc + 64'sd32768) >>> 16);
    endfunction

endpackage

// ----- hdl/wwarp_pix_if.sv -----
// Destination pixel channel and result channel interfaces.
// Depends on wwarp_pkg.

interface wwarp_pix_if;
    import wwarp_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface wwarp_res_if;
    import wwarp_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         action_code;
    logic [INDEX_W-1:0] source_index;
    logic [INDEX_W-1:0] dest_index;
    modport source (output valid, output action_code, output source_index,
                    output dest_index, input ready);
    modport sink (input valid, input action_code, input source_index,
                  input dest_index, output ready);
endinterface

// ----- hdl/water_wave_warp_address_gen.sv -----
// Water wave warp address generator: one source/destination index pair per pixel.
// Depends on wwarp_pkg and the channel interfaces in wwarp_pix_if.sv.

// Takes one destination pixel per cycle and returns one result per pixel through
// a six-stage pipeline: angle multiply, quadrant fold, sine table read, amplitude
// multiply, truncation, then linear index and action. Throughput is one pixel per
// clock while the result side keeps taking transfers, and any empty stage lets a
// new pixel in while a result waits. The sine table is constant logic built at
// elaboration, so there is no start-up sweep after reset. The user must write
// registers over the APB port only while no pixel is in flight; the block itself
// does not enforce this.
module water_wave_warp_address_gen #(
    parameter int ROW_STRIDE       = 4096,
    parameter int ROW_COUNT        = 4096,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wwarp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wwarp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wwarp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    wwarp_pix_if.sink                         pix,
    wwarp_res_if.source                       res
);
    import wwarp_pkg::*;

    localparam int P_W   = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MUL_W = ANGLE_W + P_W;
    localparam logic signed [LIN_W-1:0] FRAME_PIX = LIN_W'(ROW_STRIDE * ROW_COUNT);
    localparam logic signed [LIN_W-1:0] STRIDE    = LIN_W'(ROW_STRIDE);

    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] idx;
    } lut_sel_t;

    // ---------------- sine table ----------------
    logic [ENTRY_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam longint unsigned XQ = (HALF_PI_Q30 * gi) / SINE_TABLE_DEPTH;
        assign sine_rom[gi] = sine_entry(64'(XQ));
    end

    function automatic lut_sel_t lut_select(input logic [ANGLE_W-1:0] ang);
        logic [MUL_W-1:0] prod;
        logic [P_W-1:0]   p;
        logic [P_W-1:0]   r;
        lut_sel_t         sel;
        prod = MUL_W'(ang) * MUL_W'(4 * SINE_TABLE_DEPTH);
        p    = prod[MUL_W-1:ANGLE_W];
        if (p >= P_W'(3 * SINE_TABLE_DEPTH))
        begin
            r       = p - P_W'(3 * SINE_TABLE_DEPTH);
            sel.neg = 1'b1;
            sel.idx = IDX_W'(SINE_TABLE_DEPTH) - IDX_W'(r);
        end
        else if (p >= P_W'(2 * SINE_TABLE_DEPTH))
        begin
            r       = p - P_W'(2 * SINE_TABLE_DEPTH);
            sel.neg = 1'b1;
            sel.idx = IDX_W'(r);
        end
        else if (p >= P_W'(SINE_TABLE_DEPTH))
        begin
            r       = p - P_W'(SINE_TABLE_DEPTH);
            sel.neg = 1'b0;
            sel.idx = IDX_W'(SINE_TABLE_DEPTH) - IDX_W'(r);
        end
        else
        begin
            r       = p;
            sel.neg = 1'b0;
            sel.idx = IDX_W'(r);
        end
        return sel;
    endfunction

    // truncate Q22 toward zero
    function automatic logic signed [SRC_W-1:0] trunc_coord(input logic signed [WARP_W-1:0] t);
        logic signed [WARP_W-1:0] adj;
        adj = t + (t[WARP_W-1] ? WARP_W'((64'd1 << FRAC_SHIFT) - 64'd1) : '0);
        return SRC_W'(adj >>> FRAC_SHIFT);
    endfunction

    // ---------------- configuration ----------------
    logic [AMPL_W-1:0]   ampl_x_reg;
    logic [AMPL_W-1:0]   ampl_y_reg;
    logic [ANGLE_W-1:0]  freq_x_reg;
    logic [ANGLE_W-1:0]  freq_y_reg;
    logic [ANGLE_W-1:0]  phase_x_reg;
    logic [ANGLE_W-1:0]  phase_y_reg;
    logic [REGION_W-1:0] region_bounds_reg;
    logic [FSIZE_W-1:0]  frame_size_reg;
    reg_idx_t            cfg_sel;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_sel   = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ampl_x_reg        <= '0;
            ampl_y_reg        <= '0;
            freq_x_reg        <= '0;
            freq_y_reg        <= '0;
            phase_x_reg       <= '0;
            phase_y_reg       <= '0;
            region_bounds_reg <= '0;
            frame_size_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_AMPL_X:        ampl_x_reg        <= pwdata[AMPL_W-1:0];
                REG_AMPL_Y:        ampl_y_reg        <= pwdata[AMPL_W-1:0];
                REG_FREQ_X:        freq_x_reg        <= pwdata[ANGLE_W-1:0];
                REG_FREQ_Y:        freq_y_reg        <= pwdata[ANGLE_W-1:0];
                REG_PHASE_X:       phase_x_reg       <= pwdata[ANGLE_W-1:0];
                REG_PHASE_Y:       phase_y_reg       <= pwdata[ANGLE_W-1:0];
                REG_REGION_BOUNDS: region_bounds_reg <= pwdata[REGION_W-1:0];
                REG_FRAME_SIZE:    frame_size_reg    <= pwdata[FSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_AMPL_X:        prdata = APB_DATA_W'(ampl_x_reg);
            REG_AMPL_Y:        prdata = APB_DATA_W'(ampl_y_reg);
            REG_FREQ_X:        prdata = APB_DATA_W'(freq_x_reg);
            REG_FREQ_Y:        prdata = APB_DATA_W'(freq_y_reg);
            REG_PHASE_X:       prdata = APB_DATA_W'(phase_x_reg);
            REG_PHASE_Y:       prdata = APB_DATA_W'(phase_y_reg);
            REG_REGION_BOUNDS: prdata = APB_DATA_W'(region_bounds_reg);
            REG_FRAME_SIZE:    prdata = APB_DATA_W'(frame_size_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic [6:1] valid_reg;
    logic [6:1] stage_en;

    always_comb
    begin
        stage_en[6] = !valid_reg[6] || res.ready;
        stage_en[5] = !valid_reg[5] || stage_en[6];
        stage_en[4] = !valid_reg[4] || stage_en[5];
        stage_en[3] = !valid_reg[3] || stage_en[4];
        stage_en[2] = !valid_reg[2] || stage_en[3];
        stage_en[1] = !valid_reg[1] || stage_en[2];
    end

    assign pix.ready = stage_en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1]) valid_reg[1] <= pix.valid;
            if (stage_en[2]) valid_reg[2] <= valid_reg[1];
            if (stage_en[3]) valid_reg[3] <= valid_reg[2];
            if (stage_en[4]) valid_reg[4] <= valid_reg[3];
            if (stage_en[5]) valid_reg[5] <= valid_reg[4];
            if (stage_en[6]) valid_reg[6] <= valid_reg[5];
        end
    end

    // ---------------- stage 1: angles, dest index, region ----------------
    logic [ANGLE_W-1:0] ang_x_next;
    logic [ANGLE_W-1:0] ang_y_next;
    logic [INDEX_W-1:0] dest_next;
    logic               roi_next;
    logic               frame_next;
    logic [ANGLE_W-1:0] ang_x_reg;
    logic [ANGLE_W-1:0] ang_y_reg;
    logic [COORD_W-1:0] px1_reg;
    logic [COORD_W-1:0] py1_reg;
    logic [INDEX_W-1:0] dest1_reg;
    logic               roi1_reg;
    logic               frame1_reg;

    always_comb
    begin
        ang_x_next = ANGLE_W'(freq_x_reg * ANGLE_W'(pix.pixel_y)) + phase_x_reg;
        ang_y_next = ANGLE_W'(freq_y_reg * ANGLE_W'(pix.pixel_x)) + phase_y_reg
                     + QUARTER_TURN;
        dest_next  = INDEX_W'(pix.pixel_x)
                     + INDEX_W'(pix.pixel_y) * INDEX_W'(ROW_STRIDE);
        roi_next   = (pix.pixel_x >= region_bounds_reg[11:0])
                     && (pix.pixel_x <= region_bounds_reg[23:12])
                     && (pix.pixel_y >= region_bounds_reg[35:24])
                     && (pix.pixel_y <= region_bounds_reg[47:36]);
        frame_next = (FRAME_W'(pix.pixel_x) < frame_size_reg[FRAME_W-1:0])
                     && (FRAME_W'(pix.pixel_y) < frame_size_reg[FSIZE_W-1:FRAME_W]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            ang_x_reg  <= ang_x_next;
            ang_y_reg  <= ang_y_next;
            px1_reg    <= pix.pixel_x;
            py1_reg    <= pix.pixel_y;
            dest1_reg  <= dest_next;
            roi1_reg   <= roi_next;
            frame1_reg <= frame_next;
        end
    end

    // ---------------- stage 2: quadrant fold ----------------
    lut_sel_t           sel_x_reg;
    lut_sel_t           sel_y_reg;
    logic [COORD_W-1:0] px2_reg;
    logic [COORD_W-1:0] py2_reg;
    logic [INDEX_W-1:0] dest2_reg;
    logic               roi2_reg;
    logic               frame2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            sel_x_reg  <= lut_select(ang_x_reg);
            sel_y_reg  <= lut_select(ang_y_reg);
            px2_reg    <= px1_reg;
            py2_reg    <= py1_reg;
            dest2_reg  <= dest1_reg;
            roi2_reg   <= roi1_reg;
            frame2_reg <= frame1_reg;
        end
    end

    // ---------------- stage 3: table read ----------------
    logic [ENTRY_W-1:0]       ent_x;
    logic [ENTRY_W-1:0]       ent_y;
    logic signed [SINE_W-1:0] sine_x_reg;
    logic signed [SINE_W-1:0] sine_y_reg;
    logic [COORD_W-1:0]       px3_reg;
    logic [COORD_W-1:0]       py3_reg;
    logic [INDEX_W-1:0]       dest3_reg;
    logic                     roi3_reg;
    logic                     frame3_reg;

    assign ent_x = sine_rom[sel_x_reg.idx];
    assign ent_y = sine_rom[sel_y_reg.idx];

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            sine_x_reg <= sel_x_reg.neg ? -$signed({1'b0, ent_x}) : $signed({1'b0, ent_x});
            sine_y_reg <= sel_y_reg.neg ? -$signed({1'b0, ent_y}) : $signed({1'b0, ent_y});
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
            dest3_reg  <= dest2_reg;
            roi3_reg   <= roi2_reg;
            frame3_reg <= frame2_reg;
        end
    end

    // ---------------- stage 4: amplitude multiply ----------------
    logic signed [2*SINE_W-1:0] prod_x_reg;
    logic signed [2*SINE_W-1:0] prod_y_reg;
    logic [COORD_W-1:0]         px4_reg;
    logic [COORD_W-1:0]         py4_reg;
    logic [INDEX_W-1:0]         dest4_reg;
    logic                       roi4_reg;
    logic                       frame4_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            prod_x_reg <= $signed(ampl_x_reg) * sine_x_reg;
            prod_y_reg <= $signed(ampl_y_reg) * sine_y_reg;
            px4_reg    <= px3_reg;
            py4_reg    <= py3_reg;
            dest4_reg  <= dest3_reg;
            roi4_reg   <= roi3_reg;
            frame4_reg <= frame3_reg;
        end
    end

    // ---------------- stage 5: add base, truncate ----------------
    logic signed [WARP_W-1:0] warp_x;
    logic signed [WARP_W-1:0] warp_y;
    logic signed [SRC_W-1:0]  sx_reg;
    logic signed [SRC_W-1:0]  sy_reg;
    logic [INDEX_W-1:0]       dest5_reg;
    logic                     roi5_reg;
    logic                     frame5_reg;

    assign warp_x = $signed({2'b00, px4_reg, FRAC_SHIFT'(0)}) + WARP_W'(prod_x_reg);
    assign warp_y = $signed({2'b00, py4_reg, FRAC_SHIFT'(0)}) + WARP_W'(prod_y_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            sx_reg     <= trunc_coord(warp_x);
            sy_reg     <= trunc_coord(warp_y);
            dest5_reg  <= dest4_reg;
            roi5_reg   <= roi4_reg;
            frame5_reg <= frame4_reg;
        end
    end

    // ---------------- stage 6: linear index and action ----------------
    logic signed [LIN_W-1:0] src_lin;
    logic                    src_ok;
    action_t                 act_next;
    action_t                 act_reg;
    logic [INDEX_W-1:0]      src_reg;
    logic [INDEX_W-1:0]      dest6_reg;

    always_comb
    begin
        src_lin = LIN_W'(sx_reg) + LIN_W'(sy_reg) * STRIDE;
        src_ok  = !src_lin[LIN_W-1] && (src_lin < FRAME_PIX);
        if (roi5_reg)
        begin
            act_next = src_ok ? ACT_FETCH : ACT_SKIP;
        end
        else
        begin
            act_next = frame5_reg ? ACT_COPY : ACT_SKIP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            act_reg   <= act_next;
            src_reg   <= (act_next == ACT_FETCH) ? src_lin[INDEX_W-1:0] : '0;
            dest6_reg <= dest5_reg;
        end
    end

    assign res.valid        = valid_reg[6];
    assign res.action_code  = act_reg;
    assign res.source_index = src_reg;
    assign res.dest_index   = dest6_reg;

`ifndef SYNTHESIS
    a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.action_code == ACT_FETCH || res.source_index == '0))
        else $error("source index set without fetch");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready |=> valid_reg[1])
        else $error("accepted pixel lost at stage 1");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !res.ready |-> !pix.ready)
        else $error("input taken into a full stalled pipeline");

    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (sine_x_reg <= 16'sd16384 && sine_x_reg >= -16'sd16384
                          && sine_y_reg <= 16'sd16384 && sine_y_reg >= -16'sd16384))
        else $error("sine value out of Q1.14 range");
`endif

endmodule

// ----- verif/water_wave_warp_address_gen_test.sv -----
// Self-checking testbench for water_wave_warp_address_gen: directed probes with tabulated
// or predicted results, then fixed and randomized register settings with pixels checked against a predictor.
// Depends on wwarp_pkg, the channel interfaces in wwarp_pix_if.sv and the RTL.

module water_wave_warp_address_gen_test;
    import wwarp_pkg::*;

    localparam int MAX_W      = 4096;
    localparam int MAX_H      = 4096;
    localparam int DEPTH      = 256;
    localparam int NPROBE     = 23;
    localparam int NPHASE     = 12;
    localparam int PHASE_LEN  = 162;
    localparam int CYCLE_CAP  = 500000;

    typedef struct {
        action_t            act;
        logic [INDEX_W-1:0] src;
        logic [INDEX_W-1:0] dst;
    } warp_result_t;

    typedef struct {
        int                 cfg;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        bit                 typed;
        action_t            act;
        logic [INDEX_W-1:0] src;
        logic [INDEX_W-1:0] dst;
    } probe_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wwarp_pix_if pix ();
    wwarp_res_if res ();

    water_wave_warp_address_gen uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix),
        .res     (res)
    );

    always #6 clk = ~clk;

    int            sine_lut [0:DEPTH];
    logic [63:0]   shadow [0:7];
    logic [63:0]   cfg_next [0:7];
    warp_result_t  pending_results [$];
    int            fail_count = 0;
    int            cycles = 0;
    bit            burst_mode = 1'b0;
    bit            rx_burst = 1'b0;

    // register sets for the directed part; set 0 is the reset state
    logic [63:0] dir_cfg [0:3][0:7] = '{
        '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0},
        '{64'h7FFF, 64'h8000, 64'h0100, 64'hFFFF, 64'h0, 64'h4000,
          64'hFFF000FFF000, 64'h2001000},
        '{64'h8000, 64'h8000, 64'h0, 64'h0, 64'h4000, 64'h0,
          64'h03C0320C8064, 64'hA012C},
        '{64'h1234, 64'hFEDC, 64'h0777, 64'h0999, 64'h1111, 64'h2222,
          64'hFFF0000641F4, 64'h3FFFFFF}
    };

    probe_t probe_tab [0:NPROBE-1] = '{
        '{0, 12'h000, 12'h000, 1'b1, ACT_FETCH, 24'h0, 24'h000000},
        '{0, 12'h001, 12'h000, 1'b1, ACT_SKIP,  24'h0, 24'h000001},
        '{0, 12'h000, 12'h001, 1'b1, ACT_SKIP,  24'h0, 24'h001000},
        '{0, 12'hFFF, 12'hFFF, 1'b1, ACT_SKIP,  24'h0, 24'hFFFFFF},
        '{0, 12'hAAA, 12'h555, 1'b1, ACT_SKIP,  24'h0, 24'h555AAA},
        '{0, 12'h555, 12'hAAA, 1'b1, ACT_SKIP,  24'h0, 24'hAAA555},
        '{1, 12'h000, 12'h000, 1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{1, 12'hFFF, 12'h000, 1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{1, 12'h000, 12'hFFF, 1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{1, 12'hFFF, 12'hFFF, 1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{1, 12'h800, 12'h800, 1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{1, 12'h001, 12'hFFE, 1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{2, 12'd0,   12'd0,   1'b1, ACT_COPY,  24'h0, 24'h000000},
        '{2, 12'd300, 12'd10,  1'b1, ACT_SKIP,  24'h0, 24'h00A12C},
        '{2, 12'd299, 12'd79,  1'b1, ACT_COPY,  24'h0, 24'h04F12B},
        '{2, 12'd201, 12'd61,  1'b1, ACT_COPY,  24'h0, 24'h03D0C9},
        '{2, 12'd99,  12'd50,  1'b1, ACT_COPY,  24'h0, 24'h032063},
        '{2, 12'd150, 12'd55,  1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{2, 12'd100, 12'd50,  1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{2, 12'd200, 12'd60,  1'b0, ACT_SKIP,  24'h0, 24'h0},
        '{3, 12'd0,   12'd0,   1'b1, ACT_COPY,  24'h0, 24'h000000},
        '{3, 12'hFFF, 12'hFFF, 1'b1, ACT_COPY,  24'h0, 24'hFFFFFF},
        '{3, 12'd300, 12'd300, 1'b1, ACT_COPY,  24'h0, 24'h12C12C}
    };

    // quarter-wave table, Q30 Taylor series rounded to Q14
    function automatic void build_sine_lut();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned dv;
        longint          sum;
        for (int i = 0; i <= DEPTH; i++)
        begin
            x    = (HALF_PI_Q30 * longint'(i)) / longint'(DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 5; k++)
            begin
                dv   = (2 * k) * (2 * k + 1);
                term = ((term * x2) >> 30) / dv;
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            sine_lut[i] = int'((sum + 32768) >>> 16);
        end
    endfunction

    function automatic int sine_at(input logic [ANGLE_W-1:0] angle);
        int unsigned p;
        int unsigned q;
        int unsigned r;
        int          v;
        p = (int'(angle) * 4 * DEPTH) >> 16;
        q = (p / DEPTH) & 3;
        r = p % DEPTH;
        v = (q == 0 || q == 2) ? sine_lut[r] : sine_lut[DEPTH - r];
        return (q >= 2) ? -v : v;
    endfunction

    // coordinate plus Q8.8 * Q1.14 displacement, truncated toward zero
    function automatic longint displace(input logic [COORD_W-1:0] base,
                                        input logic [AMPL_W-1:0] ampl, input int sine);
        longint b;
        longint a;
        longint t;
        b = base;
        a = $signed(ampl);
        t = b * 4194304 + a * sine;
        if (t >= 0)
            return t >>> FRAC_SHIFT;
        return -((-t) >>> FRAC_SHIFT);
    endfunction

    function automatic warp_result_t predict_warp(input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py);
        warp_result_t       w;
        logic [ANGLE_W-1:0] ang_x;
        logic [ANGLE_W-1:0] ang_y;
        longint             sx;
        longint             sy;
        longint             src;
        longint             dst;
        logic [REGION_W-1:0] rb;
        logic [FSIZE_W-1:0] fs;
        ang_x = shadow[REG_FREQ_X][15:0] * py + shadow[REG_PHASE_X][15:0];
        ang_y = shadow[REG_FREQ_Y][15:0] * px + shadow[REG_PHASE_Y][15:0];
        sx    = displace(px, shadow[REG_AMPL_X][15:0], sine_at(ang_x));
        sy    = displace(py, shadow[REG_AMPL_Y][15:0], sine_at(ang_y + QUARTER_TURN));
        src   = sx + sy * MAX_W;
        dst   = longint'(px) + longint'(py) * MAX_W;
        rb    = shadow[REG_REGION_BOUNDS][REGION_W-1:0];
        fs    = shadow[REG_FRAME_SIZE][FSIZE_W-1:0];
        w.dst = INDEX_W'(dst);
        w.src = '0;
        if (px >= rb[11:0] && px <= rb[23:12] && py >= rb[35:24] && py <= rb[47:36])
        begin
            if (src >= 0 && src < longint'(MAX_W) * MAX_H)
            begin
                w.act = ACT_FETCH;
                w.src = INDEX_W'(src);
            end
            else
                w.act = ACT_SKIP;
        end
        else if (px < fs[12:0] && py < fs[25:13])
            w.act = ACT_COPY;
        else
            w.act = ACT_SKIP;
        return w;
    endfunction

    function automatic logic [63:0] reg_mask(input int idx);
        if (idx == REG_REGION_BOUNDS)
            return 64'hFFFF_FFFF_FFFF;
        if (idx == REG_FRAME_SIZE)
            return 64'h3FF_FFFF;
        return 64'hFFFF;
    endfunction

    task automatic apb_write(input int idx, input logic [63:0] data);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx[2:0], 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        while (!done);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        shadow[idx] = data & reg_mask(idx);
        @(posedge clk);
    endtask

    task automatic commit_regs();
        for (int r = 0; r < 8; r++)
            apb_write(r, cfg_next[r]);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input bit typed, input warp_result_t typed_res);
        int gap;
        bit took;
        gap = burst_mode ? 0 : $urandom_range(11, 0);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid   <= 1'b1;
        pix.pixel_x <= x;
        pix.pixel_y <= y;
        do
        begin
            @(negedge clk);
            took = pix.ready;
            @(posedge clk);
        end
        while (!took);
        pending_results.push_back(typed ? typed_res : predict_warp(x, y));
    endtask

    // mostly within or just around the region, otherwise anywhere
    function automatic logic [COORD_W-1:0] pick_coord(input int b, input int e);
        int lo;
        int hi;
        if (b <= e && $urandom_range(9, 0) < 7)
        begin
            lo = (b > 3) ? b - 3 : 0;
            hi = (e + 3 > 4095) ? 4095 : e + 3;
            return COORD_W'($urandom_range(hi, lo));
        end
        return COORD_W'($urandom());
    endfunction

    function automatic logic [COORD_W-1:0] region_end(input logic [COORD_W-1:0] b);
        int e;
        e = b + $urandom_range(600, 0);
        return (e > 4095) ? 12'hFFF : COORD_W'(e);
    endfunction

    task automatic make_config(input int ph);
        logic [COORD_W-1:0] xb;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] yb;
        logic [COORD_W-1:0] ye;
        logic [FRAME_W-1:0] fw;
        logic [FRAME_W-1:0] fh;
        if (ph == 0)
        begin
            cfg_next = '{64'h7FFF, 64'h7FFF, 64'hFFFF, 64'hFFFF, 64'hFFFF, 64'hFFFF,
                         64'hFFF000FFF000, 64'h3FFFFFF};
        end
        else if (ph == 1)
        begin
            cfg_next = '{64'h8000, 64'h8000, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
        end
        else
        begin
            for (int r = REG_AMPL_X; r <= REG_PHASE_Y; r++)
                cfg_next[r] = 64'($urandom_range(65535, 0));
            if ($urandom_range(1, 0))
            begin
                cfg_next[REG_FREQ_X] = 64'($urandom_range(64, 0));
                cfg_next[REG_FREQ_Y] = 64'($urandom_range(64, 0));
            end
            xb = COORD_W'($urandom());
            yb = COORD_W'($urandom());
            xe = ($urandom_range(7, 0) == 0) ? COORD_W'($urandom()) : region_end(xb);
            ye = ($urandom_range(7, 0) == 0) ? COORD_W'($urandom()) : region_end(yb);
            fw = $urandom_range(1, 0) ? FRAME_W'($urandom()) : FRAME_W'($urandom_range(4200, 0));
            fh = $urandom_range(1, 0) ? FRAME_W'($urandom()) : FRAME_W'($urandom_range(4200, 0));
            cfg_next[REG_REGION_BOUNDS] = {16'h0, ye, yb, xe, xb};
            cfg_next[REG_FRAME_SIZE]    = {38'h0, fh, fw};
            // stray bits above the register width, added to randomly chosen registers
            for (int r = 0; r < 8; r++)
                if ($urandom_range(3, 0) == 0)
                    cfg_next[r] = cfg_next[r] | ({$urandom(), $urandom()} & ~reg_mask(r));
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stalls, in-order compare
    initial
    begin
        int                 stall;
        bit                 got;
        logic [1:0]         a;
        logic [INDEX_W-1:0] s;
        logic [INDEX_W-1:0] d;
        warp_result_t       exp_res;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(11, 0);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = (res.valid === 1'b1);
                a   = res.action_code;
                s   = res.source_index;
                d   = res.dest_index;
                @(posedge clk);
            end
            while (!got);
            if (pending_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result: act=%0d src=%h dst=%h", a, s, d);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (a !== exp_res.act || s !== exp_res.src || d !== exp_res.dst)
                begin
                    if (fail_count < 10)
                        $display("mismatch: expected act=%0d src=%h dst=%h, got act=%0d src=%h dst=%h",
                                 exp_res.act, exp_res.src, exp_res.dst, a, s, d);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int           cur_cfg;
        warp_result_t typed_res;
        logic [REGION_W-1:0] rb;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        pix.valid   = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        for (int r = 0; r < 8; r++)
            shadow[r] = '0;
        build_sine_lut();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_cfg = 0;
        for (int i = 0; i < NPROBE; i++)
        begin
            if (probe_tab[i].cfg != cur_cfg)
            begin
                drain();
                cur_cfg  = probe_tab[i].cfg;
                cfg_next = dir_cfg[cur_cfg];
                commit_regs();
            end
            typed_res.act = probe_tab[i].act;
            typed_res.src = probe_tab[i].src;
            typed_res.dst = probe_tab[i].dst;
            send_pixel(probe_tab[i].x, probe_tab[i].y, probe_tab[i].typed, typed_res);
        end

        for (int ph = 0; ph < NPHASE; ph++)
        begin
            drain();
            make_config(ph);
            commit_regs();
            burst_mode = (ph % 4 == 3);
            rx_burst   = (ph % 3 == 2);
            rb         = shadow[REG_REGION_BOUNDS][REGION_W-1:0];
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (ph == 5 && n == PHASE_LEN / 2)
                    drain();
                send_pixel(pick_coord(rb[11:0], rb[23:12]), pick_coord(rb[35:24], rb[47:36]),
                           1'b0, typed_res);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- water_wave_warp_address_gen.f -----
hdl/wwarp_pkg.sv
hdl/wwarp_pix_if.sv
hdl/water_wave_warp_address_gen.sv
verif/water_wave_warp_address_gen_test.sv
